// ----- rtl/core/assert_macros.svh -----
// Concurrent assertion helpers; clk and rst_n must be in scope at each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define OSTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define OSTC_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define OSTC_ASSERT(lbl, prop, msg)
`define OSTC_ASSERT_NR(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/ostc_pkg.sv -----
`default_nettype none
package ostc_pkg;

  localparam int LEAVES_DEF      = 1024;
  localparam int COUNT_WIDTH_DEF = 17;
  localparam int LEAVES_RST_MAX  = 1024;

  localparam int RANK_W   = 11;
  localparam int ORDER_W  = 17;
  localparam int TOTAL_W  = 17;
  localparam int STATUS_W = 2;
  localparam int DELTA_W  = 2;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_K_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANK_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_COUNT      = 2'd3;

endpackage
`default_nettype wire

// ----- rtl/core/ostc_ram.sv -----
`default_nettype none
module ostc_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/ostc_walk.sv -----
`default_nettype none
module ostc_walk #(
  parameter int LEAVES      = ostc_pkg::LEAVES_DEF,
  parameter int COUNT_WIDTH = ostc_pkg::COUNT_WIDTH_DEF,
  localparam int DEPTH  = 4 * LEAVES,
  localparam int NODE_W = $clog2(DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clear_req,
  input  logic [ostc_pkg::RANK_W-1:0]         n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic [ostc_pkg::RANK_W-1:0]         in_value_rank,
  input  logic signed [ostc_pkg::DELTA_W-1:0] in_delta,
  input  logic [ostc_pkg::ORDER_W-1:0]        in_wanted_order,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ostc_pkg::RANK_W-1:0]         out_found_rank,
  output logic [ostc_pkg::STATUS_W-1:0]       out_status,
  output logic [ostc_pkg::TOTAL_W-1:0]        out_total_count,
  output logic                                ram_we,
  output logic [NODE_W-1:0]                   ram_waddr,
  output logic [COUNT_WIDTH-1:0]              ram_wdata,
  output logic [NODE_W-1:0]                   ram_raddr,
  input  logic [COUNT_WIDTH-1:0]              ram_rdata
);

  localparam int RW = ostc_pkg::RANK_W;
  localparam int KW = ostc_pkg::ORDER_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QRY   = 3'd1;
  localparam logic [2:0] S_DOWN  = 3'd2;
  localparam logic [2:0] S_UP    = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;

  localparam logic [NODE_W-1:0] ROOT      = NODE_W'(1);
  localparam logic [NODE_W-1:0] ROOT_LEFT = NODE_W'(2);
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(DEPTH - 1);

  logic [2:0]                        state_r, state_nxt;
  logic [NODE_W-1:0]                 clr_r, clr_nxt;
  logic [NODE_W-1:0]                 node_r, node_nxt;
  logic [RW-1:0]                     lo_r, lo_nxt, hi_r, hi_nxt, rank_r, rank_nxt;
  logic [KW-1:0]                     k_r, k_nxt;
  logic signed [ostc_pkg::DELTA_W-1:0] delta_r, delta_nxt;
  logic                              first_r, first_nxt;
  logic                              action_r, action_nxt;
  logic [COUNT_WIDTH-1:0]            root_r, root_nxt;
  logic [RW-1:0]                     res_found_r, res_found_nxt;
  logic [ostc_pkg::STATUS_W-1:0]     res_status_r, res_status_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [RW-1:0]                     out_found_r, out_found_nxt;
  logic [ostc_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [ostc_pkg::TOTAL_W-1:0]      out_total_r, out_total_nxt;

  logic [RW:0]              lohi_sum;
  logic [RW-1:0]            mid, mid_p1, q_lo, q_hi;
  logic [NODE_W-1:0]        node2, node2p1, q_node;
  logic                     go_left, underflow, root_full, rank_bad, k_bad;
  logic [KW-1:0]            k_sub;
  logic [COUNT_WIDTH-1:0]   upd;
  logic [31:0]              root_wide;

  assign lohi_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = lohi_sum[RW:1];
  assign mid_p1    = mid + RW'(1);
  assign node2     = {node_r[NODE_W-2:0], 1'b0};
  assign node2p1   = {node_r[NODE_W-2:0], 1'b1};
  assign go_left   = 33'(ram_rdata) >= 33'(k_r);
  assign k_sub     = k_r - KW'(ram_rdata);
  assign q_node    = go_left ? node2 : node2p1;
  assign q_lo      = go_left ? lo_r : mid_p1;
  assign q_hi      = go_left ? mid : hi_r;
  assign upd       = ram_rdata + COUNT_WIDTH'(delta_r);
  assign underflow = (delta_r == 2'sb11) ? (ram_rdata == '0) :
                     (delta_r == 2'sb10) ? (ram_rdata < COUNT_WIDTH'(2)) : 1'b0;
  assign root_full = &root_r;
  assign rank_bad  = (in_value_rank == '0) || (in_value_rank > n);
  assign k_bad     = (in_wanted_order == '0) || (33'(in_wanted_order) > 33'(root_r));
  assign root_wide = 32'(root_r);

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found_rank  = out_found_r;
  assign out_status      = out_status_r;
  assign out_total_count = out_total_r;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    node_nxt       = node_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    rank_nxt       = rank_r;
    k_nxt          = k_r;
    delta_nxt      = delta_r;
    first_nxt      = first_r;
    action_nxt     = action_r;
    root_nxt       = root_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_total_nxt  = out_total_r;
    ram_we         = 1'b0;
    ram_waddr      = node_r;
    ram_wdata      = upd;
    ram_raddr      = ROOT_LEFT;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          action_nxt     = in_action;
          rank_nxt       = in_value_rank;
          delta_nxt      = in_delta;
          k_nxt          = in_wanted_order;
          lo_nxt         = RW'(1);
          hi_nxt         = n;
          node_nxt       = ROOT;
          res_found_nxt  = '0;
          res_status_nxt = ostc_pkg::ST_OK;
          state_nxt      = S_DONE;
          if (in_action == ostc_pkg::ACT_QUERY) begin
            if (k_bad) begin
              res_status_nxt = ostc_pkg::ST_K_RANGE;
            end else if (n == RW'(1)) begin
              res_found_nxt = RW'(1);
            end else begin
              state_nxt = S_QRY;
            end
          end else begin
            if (rank_bad) begin
              res_status_nxt = ostc_pkg::ST_RANK_RANGE;
            end else if (in_delta == 2'sb00) begin
              res_status_nxt = ostc_pkg::ST_OK;
            end else if ((in_delta == 2'sb01) && root_full) begin
              res_status_nxt = ostc_pkg::ST_COUNT;
            end else begin
              state_nxt = S_DOWN;
            end
          end
        end
      end
      S_QRY: begin
        node_nxt  = q_node;
        lo_nxt    = q_lo;
        hi_nxt    = q_hi;
        ram_raddr = {q_node[NODE_W-2:0], 1'b0};
        if (!go_left) begin
          k_nxt = k_sub;
        end
        if (q_lo == q_hi) begin
          res_found_nxt  = q_lo;
          res_status_nxt = ostc_pkg::ST_OK;
          state_nxt      = S_DONE;
        end
      end
      S_DOWN: begin
        ram_raddr = node_r;
        if (lo_r == hi_r) begin
          first_nxt = 1'b1;
          state_nxt = S_UP;
        end else if (rank_r <= mid) begin
          node_nxt = node2;
          hi_nxt   = mid;
        end else begin
          node_nxt = node2p1;
          lo_nxt   = mid_p1;
        end
      end
      S_UP: begin
        ram_raddr = node_r >> 1;
        if (first_r && underflow) begin
          res_status_nxt = ostc_pkg::ST_COUNT;
          state_nxt      = S_DONE;
        end else begin
          ram_we    = 1'b1;
          first_nxt = 1'b0;
          node_nxt  = node_r >> 1;
          if (node_r == ROOT) begin
            root_nxt       = upd;
            res_status_nxt = ostc_pkg::ST_OK;
            state_nxt      = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_status_nxt = res_status_r;
          out_total_nxt  = root_wide[ostc_pkg::TOTAL_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + NODE_W'(1);
        if (clr_r == LAST_NODE) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase

    if (clear_req) begin
      state_nxt = S_CLEAR;
      clr_nxt   = '0;
      root_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      root_r      <= root_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r       <= node_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    rank_r       <= rank_nxt;
    k_r          <= k_nxt;
    delta_r      <= delta_nxt;
    first_r      <= first_nxt;
    action_r     <= action_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_total_r  <= out_total_nxt;
  end

`include "assert_macros.svh"

  `OSTC_ASSERT_NR(a_reset_clears, !rst_n |=> (state_r == S_CLEAR), "reset must start a clear pass")
  `OSTC_ASSERT(a_root_moves_on_commit, !$stable(root_r) |-> ($past(state_r) == S_UP) || $past(clear_req) || !$past(rst_n), "root count changed outside an update commit")
  `OSTC_ASSERT(a_no_raw_overlap, (state_r == S_UP) && ram_we && (node_r != ROOT) |-> (ram_raddr != ram_waddr), "read and write hit the same node")
  `OSTC_ASSERT(a_query_rank_range, (state_r == S_DONE) && (action_r == ostc_pkg::ACT_QUERY) && (res_status_r == ostc_pkg::ST_OK) |-> (res_found_r != '0) && (res_found_r <= n), "query result rank out of range")

endmodule
`default_nettype wire

// ----- rtl/core/order_statistic_count_tree_unit.sv -----
// Channel | Direction | Beat fields                                   | Handshake
// in      | input     | action, value_rank, delta, wanted_order       | in_valid / in_ready
// out     | output    | found_rank, status, total_count               | out_valid / out_ready
// cfg     | input     | wdata (leaves_in_use)                         | cfg_we, no wait
//
// A query walks down L levels and an update walks down and back up, L being the depth of the
// leaf reached, ceil(log2 n) at most. Flagged k, rank and full-root beats, zero deltas and
// one-leaf queries skip the walk; an underflow is caught at the leaf, before any write.
// One item is walked at a time; a query reads the count RAM once per level, an update twice.
// Reset and every cfg write start a clear pass over all 4*LEAVES nodes, one per cycle, with
// in_ready low. A stalled result holds in the output register while the next beat is taken.
`default_nettype none
module order_statistic_count_tree_unit #(
  parameter int LEAVES      = ostc_pkg::LEAVES_DEF,
  parameter int COUNT_WIDTH = ostc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ostc_pkg::RANK_W-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic [ostc_pkg::RANK_W-1:0]         in_value_rank,
  input  logic signed [ostc_pkg::DELTA_W-1:0] in_delta,
  input  logic [ostc_pkg::ORDER_W-1:0]        in_wanted_order,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ostc_pkg::RANK_W-1:0]         out_found_rank,
  output logic [ostc_pkg::STATUS_W-1:0]       out_status,
  output logic [ostc_pkg::TOTAL_W-1:0]        out_total_count
);

  localparam int RW         = ostc_pkg::RANK_W;
  localparam int DEPTH      = 4 * LEAVES;
  localparam int NODE_W     = $clog2(DEPTH);
  localparam int LEAVES_RST = (LEAVES > ostc_pkg::LEAVES_RST_MAX) ?
                              ostc_pkg::LEAVES_RST_MAX : LEAVES;

  logic [RW-1:0]          leaves_r, leaves_nxt;
  logic [RW-1:0]          n_eff;
  logic                   ram_we;
  logic [NODE_W-1:0]      ram_waddr, ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

  assign leaves_nxt = cfg_we ? cfg_wdata : leaves_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaves_r <= RW'(LEAVES_RST);
    end else begin
      leaves_r <= leaves_nxt;
    end
  end

  always_comb begin
    if (leaves_r == '0) begin
      n_eff = RW'(1);
    end else if (32'(leaves_r) > LEAVES) begin
      n_eff = RW'(LEAVES);
    end else begin
      n_eff = leaves_r;
    end
  end

  ostc_walk #(
    .LEAVES      (LEAVES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_walk (
    .clk             (clk),
    .rst_n           (rst_n),
    .clear_req       (cfg_we),
    .n               (n_eff),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_value_rank   (in_value_rank),
    .in_delta        (in_delta),
    .in_wanted_order (in_wanted_order),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found_rank  (out_found_rank),
    .out_status      (out_status),
    .out_total_count (out_total_count),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

  ostc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ostc_pkg::*;

  localparam int LEAVES     = LEAVES_DEF;
  localparam int COUNT_W    = COUNT_WIDTH_DEF;
  localparam int TREE_NODES = 4 * LEAVES;
  localparam int COUNT_MAX  = (1 << COUNT_W) - 1;
  localparam int RANK_ALL   = (1 << RANK_W) - 1;
  localparam int LEAVES_RST = (LEAVES > LEAVES_RST_MAX) ? LEAVES_RST_MAX : LEAVES;

  localparam logic [DELTA_W-1:0] D_NONE = 2'b00;
  localparam logic [DELTA_W-1:0] D_ADD  = 2'b01;
  localparam logic [DELTA_W-1:0] D_SUB2 = 2'b10;
  localparam logic [DELTA_W-1:0] D_SUB  = 2'b11;

  typedef struct packed {
    logic                      action;
    logic [RANK_W-1:0]         value_rank;
    logic signed [DELTA_W-1:0] delta;
    logic [ORDER_W-1:0]        wanted_order;
  } order_item_t;

  typedef struct packed {
    logic [RANK_W-1:0]   found_rank;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  total_count;
  } rank_reply_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [RANK_W-1:0]         cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_action = ACT_UPDATE;
  logic [RANK_W-1:0]         in_value_rank = '0;
  logic signed [DELTA_W-1:0] in_delta = '0;
  logic [ORDER_W-1:0]        in_wanted_order = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [RANK_W-1:0]         out_found_rank;
  logic [STATUS_W-1:0]       out_status;
  logic [TOTAL_W-1:0]        out_total_count;

  int send_idle_pct = 11;
  int recv_idle_pct = 84;

  order_item_t item_backlog[$];
  order_item_t next_beat;
  order_item_t taken_beat;
  rank_reply_t awaited_replies[$];
  rank_reply_t seen_reply;
  rank_reply_t want_reply;

  int                tree_counts [0:TREE_NODES-1];
  logic [RANK_W-1:0] leaves_cfg;
  int unsigned       placed_ranks[$];

  int mismatch_count = 0;
  int replies_checked = 0;
  int sizes_run = 1;
  int status_tally [0:3] = '{default: 0};

  order_statistic_count_tree_unit #(
    .LEAVES      (LEAVES),
    .COUNT_WIDTH (COUNT_W)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_value_rank   (in_value_rank),
    .in_delta        (in_delta),
    .in_wanted_order (in_wanted_order),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found_rank  (out_found_rank),
    .out_status      (out_status),
    .out_total_count (out_total_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int count_at(input int unsigned node);
    return (node < TREE_NODES) ? tree_counts[node] : 0;
  endfunction

  function automatic rank_reply_t predict_reply(input order_item_t it);
    int unsigned n, lo, hi, mid, node, k, left, rank, depth;
    int unsigned trail [0:15];
    int d;
    rank_reply_t r;
    n = (leaves_cfg == '0) ? 1 : (32'(leaves_cfg) > LEAVES) ? LEAVES : 32'(leaves_cfg);
    lo = 1;
    hi = n;
    node = 1;
    r = '0;
    if (it.action == ACT_QUERY) begin
      k = 32'(it.wanted_order);
      if (k == 0 || k > count_at(1)) begin
        r.status = ST_K_RANGE;
      end else begin
        while (lo < hi) begin
          mid = (lo + hi) >> 1;
          left = count_at(2 * node);
          if (left >= k) begin
            node = 2 * node;
            hi = mid;
          end else begin
            k = k - left;
            node = 2 * node + 1;
            lo = mid + 1;
          end
        end
        r.found_rank = RANK_W'(lo);
      end
    end else begin
      rank = 32'(it.value_rank);
      d = it.delta[1] ? int'(it.delta[0]) - 2 : int'(it.delta[0]);
      if (rank == 0 || rank > n) begin
        r.status = ST_RANK_RANGE;
      end else begin
        trail[0] = 1;
        depth = 1;
        while (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (rank <= mid) begin
            node = 2 * node;
            hi = mid;
          end else begin
            node = 2 * node + 1;
            lo = mid + 1;
          end
          trail[depth] = node;
          depth++;
        end
        if (d > 0 && count_at(1) + d > COUNT_MAX) begin
          r.status = ST_COUNT;
        end else if (d < 0 && count_at(node) < -d) begin
          r.status = ST_COUNT;
        end else begin
          for (int i = 0; i < depth; i++) begin
            if (trail[i] < TREE_NODES) tree_counts[trail[i]] += d;
          end
        end
      end
    end
    r.total_count = TOTAL_W'(count_at(1));
    return r;
  endfunction

  function automatic order_item_t upd(input int unsigned rank, input logic [DELTA_W-1:0] d);
    order_item_t it;
    it.action = ACT_UPDATE;
    it.value_rank = RANK_W'(rank);
    it.delta = $signed(d);
    it.wanted_order = ORDER_W'($urandom);
    return it;
  endfunction

  function automatic order_item_t qry(input int unsigned k);
    order_item_t it;
    it.action = ACT_QUERY;
    it.value_rank = RANK_W'($urandom);
    it.delta = $signed(DELTA_W'($urandom));
    it.wanted_order = ORDER_W'(k);
    return it;
  endfunction

  task automatic stage_item(input order_item_t it);
    item_backlog.insert(item_backlog.size(), it);
  endtask

  task automatic drop_placed(input int unsigned rank);
    foreach (placed_ranks[i]) begin
      if (placed_ranks[i] == rank) begin
        placed_ranks.delete(i);
        return;
      end
    end
  endtask

  task automatic queue_random_beats(input int unsigned n, input int count);
    order_item_t beat;
    int roll, mix, hits;
    int unsigned rank;
    repeat (count) begin
      roll = $urandom_range(99);
      rank = $urandom_range(n, 1);
      if (roll < 55) begin
        mix = $urandom_range(99);
        if (placed_ranks.size() != 0 && $urandom_range(99) < ((mix < 70) ? 30 : 75))
          rank = placed_ranks[$urandom_range(placed_ranks.size() - 1)];
        if (mix < 70) begin
          beat = upd(rank, D_ADD);
          placed_ranks.insert(placed_ranks.size(), rank);
        end else if (mix < 85) begin
          beat = upd(rank, D_SUB);
          drop_placed(rank);
        end else if (mix < 93) begin
          beat = upd(rank, D_SUB2);
          hits = 0;
          foreach (placed_ranks[i]) if (placed_ranks[i] == rank) hits++;
          if (hits >= 2) begin
            drop_placed(rank);
            drop_placed(rank);
          end
        end else begin
          beat = upd(rank, D_NONE);
        end
      end else if (roll < 85) begin
        beat = qry($urandom_range(placed_ranks.size() + 1, 1));
      end else if (roll < 90) begin
        beat = qry($urandom_range(1) ? 0 : $urandom);
      end else if (roll < 95) begin
        beat = upd($urandom_range(1) ? 0 : $urandom_range(RANK_ALL, n + 1),
                   DELTA_W'($urandom));
      end else begin
        beat = upd($urandom_range(RANK_ALL), DELTA_W'($urandom));
        beat.action = 1'($urandom);
      end
      stage_item(beat);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (item_backlog.size() != 0 || in_valid || awaited_replies.size() != 0);
  endtask

  task automatic apply_leaves(input int unsigned value);
    wait_drained();
    repeat (30) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= RANK_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    placed_ranks.delete();
    sizes_run++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = item_backlog.pop_front();
        in_valid <= 1'b1;
        in_action <= next_beat.action;
        in_value_rank <= next_beat.value_rank;
        in_delta <= next_beat.delta;
        in_wanted_order <= next_beat.wanted_order;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      tree_counts = '{default: 0};
      leaves_cfg = RANK_W'(LEAVES_RST);
    end else begin
      if (cfg_we) begin
        leaves_cfg = cfg_wdata;
        tree_counts = '{default: 0};
      end
      if (in_valid && in_ready) begin
        taken_beat.action = in_action;
        taken_beat.value_rank = in_value_rank;
        taken_beat.delta = in_delta;
        taken_beat.wanted_order = in_wanted_order;
        awaited_replies.insert(awaited_replies.size(), predict_reply(taken_beat));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen_reply.found_rank = out_found_rank;
        seen_reply.status = out_status;
        seen_reply.total_count = out_total_count;
        replies_checked++;
        status_tally[out_status]++;
        if (awaited_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected beat: rank %0d status %0d total %0d", seen_reply.found_rank,
                     seen_reply.status, seen_reply.total_count);
        end else begin
          want_reply = awaited_replies.pop_front();
          if (seen_reply.found_rank !== want_reply.found_rank ||
              seen_reply.status !== want_reply.status ||
              seen_reply.total_count !== want_reply.total_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("beat %0d: want rank %0d status %0d total %0d, got %0d %0d %0d",
                       replies_checked, want_reply.found_rank, want_reply.status,
                       want_reply.total_count, seen_reply.found_rank, seen_reply.status,
                       seen_reply.total_count);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    stage_item(qry(0));
    stage_item(qry(1));
    stage_item(upd(0, D_ADD));
    stage_item(upd(LEAVES + 1, D_ADD));
    stage_item(upd(RANK_ALL, D_SUB));
    stage_item(upd(0, D_NONE));
    stage_item(upd(1, D_SUB));
    stage_item(upd(1, D_ADD));
    stage_item(upd(LEAVES, D_ADD));
    stage_item(upd(LEAVES / 2, D_ADD));
    stage_item(upd(LEAVES / 2 + 1, D_ADD));
    stage_item(upd(LEAVES, D_ADD));
    stage_item(upd(7, D_NONE));
    stage_item(upd(LEAVES, D_SUB2));
    stage_item(upd(1, D_SUB2));
    stage_item(qry(1));
    stage_item(qry(2));
    stage_item(qry(3));
    stage_item(qry(4));
    stage_item(qry(COUNT_MAX));
    stage_item(upd(LEAVES / 2 + 1, D_SUB));
    stage_item(qry(2));
    stage_item(qry(3));
    queue_random_beats(LEAVES, 120);

    apply_leaves(37);
    queue_random_beats(37, 100);

    apply_leaves(0);
    send_idle_pct = 84;
    recv_idle_pct = 11;
    queue_random_beats(1, 60);
    apply_leaves(2);
    queue_random_beats(2, 80);
    apply_leaves(RANK_ALL);
    queue_random_beats(LEAVES, 100);

    apply_leaves(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_beats(600, 50);
    wait_drained();
    queue_random_beats(600, 50);
    apply_leaves(LEAVES);
    queue_random_beats(LEAVES, 60);

    apply_leaves(1);
    stage_item(upd(1, D_ADD));
    stage_item(upd(1, D_ADD));
    stage_item(upd(1, D_ADD));
    stage_item(qry(3));
    stage_item(qry(4));
    stage_item(qry(0));
    stage_item(upd(1, D_SUB2));
    stage_item(upd(1, D_ADD));
    stage_item(upd(1, D_NONE));
    stage_item(upd(2, D_ADD));
    stage_item(upd(1, D_SUB));
    stage_item(upd(1, D_SUB));
    stage_item(upd(1, D_SUB));

    wait_drained();
    repeat (40) @(posedge clk);
    $display("checked %0d result beats over %0d tree sizes and three idle mixes",
             replies_checked, sizes_run);
    $display("status mix: ok %0d, k range %0d, rank range %0d, count limit %0d",
             status_tally[ST_OK], status_tally[ST_K_RANGE], status_tally[ST_RANK_RANGE],
             status_tally[ST_COUNT]);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
